@@ design/mas_pkg.sv @@
`timescale 1ns / 1ps
// mas_pkg: shared constants, action codes, sequencer states and the
// control word handed from the sequencer to the multiply-accumulate path.
// No dependencies.
package mas_pkg;

	localparam int DIM_DEF       = 4;
	localparam int ELEM_BITS_DEF = 8;
	localparam int ACT_W         = 2;

	typedef logic [ACT_W-1:0] action_t;

	localparam action_t ACT_LOAD_A  = 2'd0;
	localparam action_t ACT_LOAD_B  = 2'd1;
	localparam action_t ACT_COMPUTE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} seq_state_t;

	// one dot-product term in flight
	typedef struct packed {
		logic vld;
		logic first;   // k == 0, restart accumulator
		logic last_k;  // k == DIM-1, result complete after this term
		logic cap_a;   // A read is A[r][c]
		logic cap_b;   // B read is B[r][c]
	} mac_ctl_t;

endpackage

@@ design/mas_mem.sv @@
`timescale 1ns / 1ps
// mas_mem: single-port-write, single-port-read synchronous RAM, read data
// registered. No dependencies.
module mas_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/mas_mac.sv @@
`timescale 1ns / 1ps
// mas_mac: multiply-accumulate datapath for one result element, plus capture
// of A[r][c] and B[r][c] for the sum and difference. Depends on mas_pkg.
module mas_mac #(
	parameter int ELEM_BITS = 8,
	parameter int PROD_W    = 18
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mas_pkg::mac_ctl_t      ctl,        // aligned with the memory read address
	input  logic signed [ELEM_BITS-1:0] a_rd,  // memory read data, registered from that address
	input  logic signed [ELEM_BITS-1:0] b_rd,
	output logic                   done,       // acc, sum, diff final and held
	output logic signed [ELEM_BITS:0]   sum,
	output logic signed [ELEM_BITS:0]   diff,
	output logic signed [PROD_W-1:0]    acc
);
	import mas_pkg::*;

	localparam int SUM_W = ELEM_BITS + 1;

	mac_ctl_t ctl_s1, ctl_s2;
	logic signed [2*ELEM_BITS-1:0] prod_s2;
	logic signed [ELEM_BITS-1:0]   a_q, b_q;
	logic signed [PROD_W-1:0]      acc_q;
	logic                          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.vld && ctl_s2.last_k;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_rd * b_rd;
		if (ctl_s1.vld && ctl_s1.cap_a) begin
			a_q <= a_rd;
		end
		if (ctl_s1.vld && ctl_s1.cap_b) begin
			b_q <= b_rd;
		end
		if (ctl_s2.vld) begin
			acc_q <= (ctl_s2.first ? PROD_W'(0) : acc_q) + PROD_W'(prod_s2);
		end
	end

	assign done = done_q;
	assign sum  = SUM_W'(a_q) + SUM_W'(b_q);
	assign diff = SUM_W'(a_q) - SUM_W'(b_q);
	assign acc  = acc_q;

endmodule

@@ design/matrix_add_sub_mul_4x4.sv @@
`timescale 1ns / 1ps
// matrix_add_sub_mul_4x4: DIM x DIM signed matrix unit, element sum, difference
// and matrix product. Depends on mas_pkg, mas_mem, mas_mac.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: action; tdata: row, col, value
//  m_*     | out | m_tvalid/m_tready  | tdata: out_row, out_col, sum, difference,
//          |     |                    |        product; tlast: last of a run
//
// Loads may stream back to back.
// A compute beat runs DIM*DIM results, each as DIM reads (one dot-product term
// per cycle through the single read port of each matrix memory), then a
// multiply/accumulate drain and one emit step. s_tready is low meanwhile.
// A stalled sink holds the sequencer in its emit step; nothing is dropped.
// arst_n clears control only; matrix contents are undefined until loaded.
module matrix_add_sub_mul_4x4
	import mas_pkg::*;
#(
	parameter int DIM       = mas_pkg::DIM_DEF,
	parameter int ELEM_BITS = mas_pkg::ELEM_BITS_DEF,
	localparam int IDX_W    = $clog2(DIM),
	localparam int SUM_W    = ELEM_BITS + 1,
	localparam int PROD_W   = 2 * ELEM_BITS + $clog2(DIM),
	localparam int S_DATA_W = ((2 * IDX_W + ELEM_BITS + 7) / 8) * 8,
	localparam int M_DATA_W = ((2 * IDX_W + 2 * SUM_W + PROD_W + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [S_DATA_W-1:0]       s_tdata,   // row, col, value, zero pad
	input  logic [mas_pkg::ACT_W-1:0] s_tuser,   // action
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [M_DATA_W-1:0]       m_tdata,   // out_row, out_col, sum, difference,
	                                             // product, zero pad
	output logic                      m_tlast    // last
);
	import mas_pkg::*;

	localparam int DEPTH = DIM * DIM;
	localparam int AW    = $clog2(DEPTH);

	// input unpack
	action_t                 in_act;
	logic [IDX_W-1:0]        in_row, in_col;
	logic [ELEM_BITS-1:0]    in_val;
	logic                    in_fire, load_ok, we_a, we_b;
	logic [AW-1:0]           waddr;

	assign in_act = s_tuser;
	assign in_row = s_tdata[IDX_W-1:0];
	assign in_col = s_tdata[2*IDX_W-1:IDX_W];
	assign in_val = s_tdata[2*IDX_W +: ELEM_BITS];

	// sequencer
	seq_state_t       state_q, state_d;
	logic [IDX_W-1:0] r_q, c_q, k_q;
	logic             k_end, c_end, r_end, emit_fire;
	mac_ctl_t         ctl;
	logic [AW-1:0]    raddr_a, raddr_b;

	// datapath
	logic [ELEM_BITS-1:0]      a_rd, b_rd;
	logic                      mac_done;
	logic signed [SUM_W-1:0]   mac_sum, mac_diff;
	logic signed [PROD_W-1:0]  mac_acc;

	// output register
	logic                     m_tvalid_q, last_q;
	logic [IDX_W-1:0]         row_q, col_q;
	logic [SUM_W-1:0]         sum_q, diff_q;
	logic [PROD_W-1:0]        prod_q;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// loads outside the matrix are dropped
	assign load_ok = in_fire
		&& ({1'b0, in_row} < (IDX_W + 1)'(DIM))
		&& ({1'b0, in_col} < (IDX_W + 1)'(DIM));
	assign we_a  = load_ok && (in_act == ACT_LOAD_A);
	assign we_b  = load_ok && (in_act == ACT_LOAD_B);
	assign waddr = AW'(AW'(in_row) * AW'(DIM) + AW'(in_col));

	// A walks row r, B walks column c
	assign raddr_a = AW'(AW'(r_q) * AW'(DIM) + AW'(k_q));
	assign raddr_b = AW'(AW'(k_q) * AW'(DIM) + AW'(c_q));

	assign k_end = (k_q == IDX_W'(DIM - 1));
	assign c_end = (c_q == IDX_W'(DIM - 1));
	assign r_end = (r_q == IDX_W'(DIM - 1));

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		emit_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_act == ACT_COMPUTE) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				ctl.vld    = 1'b1;
				ctl.first  = (k_q == '0);
				ctl.last_k = k_end;
				ctl.cap_a  = (k_q == c_q);
				ctl.cap_b  = (k_q == r_q);
				if (k_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (mac_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					emit_fire = 1'b1;
					state_d   = (r_end && c_end) ? ST_IDLE : ST_ISSUE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				r_q <= '0;
				c_q <= '0;
				k_q <= '0;
			end
			if (state_q == ST_ISSUE) begin
				k_q <= k_end ? '0 : k_q + 1'b1;
			end
			if (emit_fire) begin
				c_q <= c_end ? '0 : c_q + 1'b1;
				if (c_end) begin
					r_q <= r_end ? '0 : r_q + 1'b1;
				end
			end
		end
	end

	mas_mem #(.DEPTH(DEPTH), .WIDTH(ELEM_BITS)) u_mem_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (in_val),
		.raddr (raddr_a),
		.rdata (a_rd)
	);

	mas_mem #(.DEPTH(DEPTH), .WIDTH(ELEM_BITS)) u_mem_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (in_val),
		.raddr (raddr_b),
		.rdata (b_rd)
	);

	mas_mac #(.ELEM_BITS(ELEM_BITS), .PROD_W(PROD_W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.a_rd   (a_rd),
		.b_rd   (b_rd),
		.done   (mac_done),
		.sum    (mac_sum),
		.diff   (mac_diff),
		.acc    (mac_acc)
	);

	// output register: one result beat, refilled by the next emit, which may coincide with the beat being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			row_q  <= r_q;
			col_q  <= c_q;
			sum_q  <= mac_sum;
			diff_q <= mac_diff;
			prod_q <= mac_acc;
			last_q <= r_end && c_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'({prod_q, diff_q, sum_q, col_q, row_q});
	assign m_tlast  = last_q;

	// accumulator completes only while the sequencer waits for it
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_DRAIN)
		else $error("mac done outside drain");

	// drain of the multiply/accumulate path: mac_done arrives through the ctl_s2 and done_q registers
	a_drain_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_DRAIN) |-> ##2 mac_done)
		else $error("mac drain latency mismatch");

	// matrices change only between runs
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(we_a || we_b) |-> state_q == ST_IDLE && !ctl.vld)
		else $error("matrix write during a run");

endmodule
